>>> sv/owb_pkg.sv
// Shared types, codes and constants of the one-wire bus master.
package owb_pkg;

  localparam int unsigned TickW      = 10;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned ActionW    = 3;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned RdShift    = (8 - BitsPerByte) % 8;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutDataW   = 16;

  localparam logic [TickW-1:0] RstLowDefault   = 10'd480;
  localparam logic [TickW-1:0] PresWaitDefault = 10'd60;
  localparam logic [TickW-1:0] RstRecDefault   = 10'd420;
  localparam logic [TickW-1:0] SlotStartDefault = 10'd1;
  localparam logic [TickW-1:0] WrHoldDefault   = 10'd60;
  localparam logic [TickW-1:0] RdSampleDefault = 10'd14;
  localparam logic [TickW-1:0] RdTailDefault   = 10'd45;

  typedef enum logic [ActionW-1:0] {
    ActTick   = 3'd0,
    ActReset  = 3'd1,
    ActWrByte = 3'd2,
    ActRdByte = 3'd3,
    ActWrBit  = 3'd4,
    ActRdBit  = 3'd5
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRstLow    = 3'd0,
    CfgPresWait  = 3'd1,
    CfgRstRec    = 3'd2,
    CfgSlotStart = 3'd3,
    CfgWrHold    = 3'd4,
    CfgRdSample  = 3'd5,
    CfgRdTail    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [TickW-1:0] rst_low;
    logic [TickW-1:0] pres_wait;
    logic [TickW-1:0] rst_rec;
    logic [TickW-1:0] slot_start;
    logic [TickW-1:0] wr_hold;
    logic [TickW-1:0] rd_sample;
    logic [TickW-1:0] rd_tail;
  } cfg_t;

  typedef struct packed {
    logic             presence_missing;
    logic [ByteW-1:0] read_data;
    logic             rejected;
    logic             done_res;
    logic             busy_res;
    logic             drive_low;
  } res_t;

endpackage

>>> sv/onewire_bus_master.sv
// Top level of the one-wire bus master: input register, sequencer and result register.
// An accepted input item goes through the input register, then the result register.
// Throughput: one item per cycle unless the output stalls; one sequencer step per item.
// While a result waits, an input item is still taken only if the input register is empty.
// Reset is asynchronous and active low; it empties both registers, idles the sequencer
// and loads the timing registers with their default tick counts.
module onewire_bus_master (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [owb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [owb_pkg::TickW-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: action[2:0], data_in[10:3], line_level[11], zero pad.
  input  logic [owb_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0: drive_low, busy_res, done_res, rejected, read_data[11:4],
  // presence_missing[12], zero pad.
  output logic [owb_pkg::OutDataW-1:0]  m_axis_tdata
);
  import owb_pkg::*;

  logic                 in_valid_q;
  logic [InDataW-1:0]   in_data_q;
  logic                 out_valid_q;
  logic [OutDataW-1:0]  out_data_q;
  logic                 advance;
  logic                 fire;
  cfg_t                 cfg;
  res_t                 res;

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
    end
    if (fire) begin
      out_data_q <= {3'b000, res.presence_missing, res.read_data, res.rejected,
                     res.done_res, res.busy_res, res.drive_low};
    end
  end

  owb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  owb_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .action_i (in_data_q[2:0]),
    .data_i   (in_data_q[10:3]),
    .line_i   (in_data_q[11]),
    .cfg_i    (cfg),
    .res_o    (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> sv/owb_cfg.sv
// Timing configuration registers of the one-wire bus master.
module owb_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [owb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [owb_pkg::TickW-1:0]    cfg_data_i,
  output owb_pkg::cfg_t                cfg_o
);
  import owb_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rst_low    <= RstLowDefault;
      cfg_q.pres_wait  <= PresWaitDefault;
      cfg_q.rst_rec    <= RstRecDefault;
      cfg_q.slot_start <= SlotStartDefault;
      cfg_q.wr_hold    <= WrHoldDefault;
      cfg_q.rd_sample  <= RdSampleDefault;
      cfg_q.rd_tail    <= RdTailDefault;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRstLow:    cfg_q.rst_low    <= cfg_data_i;
        CfgPresWait:  cfg_q.pres_wait  <= cfg_data_i;
        CfgRstRec:    cfg_q.rst_rec    <= cfg_data_i;
        CfgSlotStart: cfg_q.slot_start <= cfg_data_i;
        CfgWrHold:    cfg_q.wr_hold    <= cfg_data_i;
        CfgRdSample:  cfg_q.rd_sample  <= cfg_data_i;
        CfgRdTail:    cfg_q.rd_tail    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> sv/owb_core.sv
// Bus sequencer: phase state machine, tick counter and shift register.
module owb_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  logic [owb_pkg::ActionW-1:0]  action_i,
  input  logic [owb_pkg::ByteW-1:0]    data_i,
  input  logic                         line_i,
  input  owb_pkg::cfg_t                cfg_i,
  output owb_pkg::res_t                res_o
);
  import owb_pkg::*;

  typedef enum logic [2:0] {
    PhIdle, PhRstLow, PhRstWait, PhRstRec, PhSlotStart, PhWrHold, PhRdWait, PhRdTail
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [ActionW-1:0] kind_q, kind_d;
  logic [TickW-1:0]   tick_q, tick_d;
  logic [3:0]         bits_q, bits_d;
  logic [ByteW-1:0]   shift_q, shift_d;
  logic               pres_q, pres_d;

  always_comb begin
    logic             is_cmd;
    logic             is_rd;
    phase_e           ph;
    logic [TickW-1:0] len;
    logic [TickW-1:0] tick_inc;
    logic [3:0]       bits_dec;

    is_cmd = (action_i == ActReset) || (action_i == ActWrByte) || (action_i == ActRdByte) ||
             (action_i == ActWrBit) || (action_i == ActRdBit);
    phase_d = phase_q;
    kind_d  = kind_q;
    tick_d  = tick_q;
    bits_d  = bits_q;
    shift_d = shift_q;
    pres_d  = pres_q;
    res_o   = '0;

    if (phase_q != PhIdle) begin
      res_o.rejected = is_cmd;
    end else if (is_cmd) begin
      kind_d = action_i;
      tick_d = '0;
      if (action_i == ActReset) begin
        phase_d = PhRstLow;
        bits_d  = '0;
      end else begin
        phase_d = PhSlotStart;
        bits_d  = (action_i == ActWrBit || action_i == ActRdBit) ? 4'd1 : 4'(BitsPerByte);
        if (action_i == ActWrByte) begin
          shift_d = data_i;
        end else if (action_i == ActWrBit) begin
          shift_d = {{(ByteW-1){1'b0}}, data_i[0]};
        end else begin
          shift_d = '0;
        end
      end
    end

    ph       = phase_d;
    is_rd    = (kind_d == ActRdByte) || (kind_d == ActRdBit);
    tick_inc = tick_d + 1'b1;
    bits_dec = bits_d - 1'b1;
    unique case (ph)
      PhRstLow:    len = cfg_i.rst_low;
      PhRstWait:   len = cfg_i.pres_wait;
      PhRstRec:    len = cfg_i.rst_rec;
      PhSlotStart: len = cfg_i.slot_start;
      PhWrHold:    len = cfg_i.wr_hold;
      PhRdWait:    len = cfg_i.rd_sample;
      default:     len = cfg_i.rd_tail;
    endcase
    if (len == '0) begin
      len = TickW'(1);
    end

    if (ph != PhIdle) begin
      res_o.drive_low = (ph == PhRstLow) || (ph == PhSlotStart) ||
                        ((ph == PhWrHold) && !shift_d[0]);
      tick_d = tick_inc;
      if (tick_inc >= len) begin
        tick_d = '0;
        unique case (ph)
          PhRstLow: phase_d = PhRstWait;
          PhRstWait: begin
            pres_d  = line_i;
            phase_d = PhRstRec;
          end
          PhRstRec: begin
            phase_d        = PhIdle;
            res_o.done_res = 1'b1;
          end
          PhSlotStart: phase_d = is_rd ? PhRdWait : PhWrHold;
          PhRdWait: begin
            shift_d = {line_i, shift_d[ByteW-1:1]};
            phase_d = PhRdTail;
          end
          PhWrHold, PhRdTail: begin
            if (ph == PhWrHold) begin
              shift_d = {1'b0, shift_d[ByteW-1:1]};
            end
            bits_d = bits_dec;
            if (bits_dec == '0) begin
              phase_d        = PhIdle;
              res_o.done_res = 1'b1;
              if (kind_d == ActRdByte) begin
                res_o.read_data = shift_d >> RdShift;
              end else if (kind_d == ActRdBit) begin
                res_o.read_data = {{(ByteW-1){1'b0}}, shift_d[ByteW-1]};
              end
            end else begin
              phase_d = PhSlotStart;
            end
          end
          default: ;
        endcase
      end
    end

    res_o.busy_res         = (phase_d != PhIdle);
    res_o.presence_missing = pres_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      kind_q  <= '0;
      tick_q  <= '0;
      bits_q  <= '0;
      shift_q <= '0;
      pres_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      tick_q  <= tick_d;
      bits_q  <= bits_d;
      shift_q <= shift_d;
      pres_q  <= pres_d;
    end
  end

endmodule

>>> sv/owb_chk.sv
// Port-level checker of the one-wire bus master and its bind to the top level.
module owb_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [owb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input logic [owb_pkg::TickW-1:0]     cfg_data_i,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [owb_pkg::InDataW-1:0]   s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [owb_pkg::OutDataW-1:0]  m_axis_tdata
);

  // The input side only stalls when a result is waiting at the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a waiting result");

  // A finished command leaves the sequencer idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2]) |-> !m_axis_tdata[1])
    else $error("done reported while still busy");

  // Read data only appears on the item that completes a command.
  a_data_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[11:4] != 8'd0)) |-> m_axis_tdata[2])
    else $error("read data without done");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind onewire_bus_master owb_chk u_owb_chk (.*);
